>>> src/cefp_pkg.sv
// ============================================================================
// cefp_pkg - shared types and constants of the Canny edge front end
// Payload structs, register indexes, sector and class codes, step control.
// ============================================================================
`default_nettype none

package cefp_pkg;

    typedef struct packed {
        logic       command;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } in_t;

    typedef struct packed {
        logic [1:0] edge_class;
        logic [7:0] magnitude;
        logic       last_pixel;
    } out_t;

    localparam int CFG_DATA_BITS = 12;

    typedef enum logic [1:0] {
        REG_FRAME_WIDTH,
        REG_FRAME_HEIGHT,
        REG_WEAK_LEVEL,
        REG_STRONG_LEVEL
    } cfg_reg_t;

    localparam logic CMD_PIXEL = 1'b0;

    typedef enum logic [1:0] {
        SEC_HORZ,
        SEC_DIAG_UP,
        SEC_VERT,
        SEC_DIAG_DOWN
    } sector_t;

    localparam logic [1:0] CLASS_NONE   = 2'd0;
    localparam logic [1:0] CLASS_WEAK   = 2'd1;
    localparam logic [1:0] CLASS_STRONG = 2'd2;

    // gray = x / 100 as (x * 5243) >> 19, exact for x below 25600
    localparam int GRAY_RECIP = 5243;
    localparam int GRAY_SHIFT = 19;

    localparam int TAN_LOW  = 106;
    localparam int TAN_HIGH = 618;

    localparam int COL_BITS   = 12;
    localparam int NUM_STAGES = 4;
    localparam int STG_GRAY   = 0;
    localparam int STG_BLUR   = 1;
    localparam int STG_SOBEL  = 2;
    localparam int STG_SUPP   = 3;

    localparam int PIPE_DEPTH = 8;
    localparam int OUT_DEPTH  = 16;

    typedef struct packed {
        logic                go;
        logic [1:0]          cur_slot;
        logic [COL_BITS-1:0] cur_col;
        logic [1:0]          nxt_slot;
        logic [COL_BITS-1:0] nxt_col;
        logic                border;
        logic                last;
    } stage_t;

    typedef struct packed {
        stage_t [NUM_STAGES-1:0] stg;
    } step_t;

endpackage

`default_nettype wire

>>> src/cefp_ram.sv
// ============================================================================
// cefp_ram - generic line store
// One write port, one read port, registered read data.
// ============================================================================
`default_nettype none

module cefp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> src/cefp_ctrl.sv
// ============================================================================
// cefp_ctrl - stage sequencer
// Raster positions and row slots of the four stages, lead counters between them;
// decides per request which stages move and where they read and write.
// ============================================================================
`default_nettype none

module cefp_ctrl #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4095,
    localparam int WW = $clog2(MAX_WIDTH + 1),
    localparam int HW = $clog2(MAX_HEIGHT + 1)
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            step_en,
    input  wire logic            pixel,
    input  wire logic [WW-1:0]   w_use,
    input  wire logic [HW-1:0]   h_use,
    output cefp_pkg::step_t      step
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int LW = $clog2(MAX_WIDTH + 4) + 1;
    localparam int NS = cefp_pkg::NUM_STAGES;

    logic [CW-1:0] col_reg  [NS];
    logic [CW-1:0] col_next [NS];
    logic [RW-1:0] row_reg  [NS];
    logic [RW-1:0] row_next [NS];
    logic [1:0]    slot_reg [NS];
    logic [1:0]    slot_next[NS];
    logic          go       [NS];

    logic [LW-1:0] lead_g_reg, lead_b_reg, lead_m_reg;
    logic [LW-1:0] lead_g_next, lead_b_next, lead_m_next;
    logic [LW-1:0] lg1, lb1, lm1;

    function automatic logic [LW-1:0] need_f(input logic [RW-1:0] row,
                                             input logic [CW-1:0] col,
                                             input logic [WW-1:0] w,
                                             input logic [HW-1:0] h);
        logic [LW-1:0] wl;
        wl = LW'(w);
        if (HW'(row) + HW'(1) >= h) begin
            return wl - LW'(col);
        end else if (HW'(row) + HW'(2) == h && WW'(col) + WW'(1) >= w) begin
            return wl + LW'(1);
        end else begin
            return wl + LW'(2);
        end
    endfunction

    always_comb begin
        logic end_col;
        logic end_row;
        lg1 = lead_g_reg + LW'(pixel);
        go[cefp_pkg::STG_GRAY] = pixel;
        go[cefp_pkg::STG_BLUR] =
            lg1 >= need_f(row_reg[1], col_reg[1], w_use, h_use);
        lead_g_next = lg1 - LW'(go[cefp_pkg::STG_BLUR]);
        lb1 = lead_b_reg + LW'(go[cefp_pkg::STG_BLUR]);
        go[cefp_pkg::STG_SOBEL] =
            lb1 >= need_f(row_reg[2], col_reg[2], w_use, h_use);
        lead_b_next = lb1 - LW'(go[cefp_pkg::STG_SOBEL]);
        lm1 = lead_m_reg + LW'(go[cefp_pkg::STG_SOBEL]);
        go[cefp_pkg::STG_SUPP] =
            lm1 >= need_f(row_reg[3], col_reg[3], w_use, h_use);
        lead_m_next = lm1 - LW'(go[cefp_pkg::STG_SUPP]);

        for (int i = 0; i < NS; i++) begin
            end_col = WW'(col_reg[i]) + WW'(1) >= w_use;
            end_row = HW'(row_reg[i]) + HW'(1) >= h_use;
            if (end_col) begin
                col_next[i]  = '0;
                slot_next[i] = slot_reg[i] + 2'd1;
                row_next[i]  = end_row ? '0 : row_reg[i] + RW'(1);
            end else begin
                col_next[i]  = col_reg[i] + CW'(1);
                slot_next[i] = slot_reg[i];
                row_next[i]  = row_reg[i];
            end
            step.stg[i].go       = go[i];
            step.stg[i].cur_slot = slot_reg[i];
            step.stg[i].cur_col  = cefp_pkg::COL_BITS'(col_reg[i]);
            step.stg[i].nxt_slot = slot_next[i];
            step.stg[i].nxt_col  = cefp_pkg::COL_BITS'(col_next[i]);
            step.stg[i].border   = row_reg[i] == '0 || end_row ||
                                   col_reg[i] == '0 || end_col;
            step.stg[i].last     = end_col && end_row;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NS; i++) begin
                col_reg[i]  <= '0;
                row_reg[i]  <= '0;
                slot_reg[i] <= '0;
            end
            lead_g_reg <= '0;
            lead_b_reg <= '0;
            lead_m_reg <= '0;
        end else if (step_en) begin
            for (int i = 0; i < NS; i++) begin
                if (go[i]) begin
                    col_reg[i]  <= col_next[i];
                    row_reg[i]  <= row_next[i];
                    slot_reg[i] <= slot_next[i];
                end
            end
            lead_g_reg <= lead_g_next;
            lead_b_reg <= lead_b_next;
            lead_m_reg <= lead_m_next;
        end
    end

endmodule

`default_nettype wire

>>> src/cefp_fifo.sv
// ============================================================================
// cefp_fifo - result queue
// Holds finished results so requests keep flowing while the sink stalls.
// ============================================================================
`default_nettype none

module cefp_fifo (
    input  wire logic                                         aclk,
    input  wire logic                                         aresetn,
    input  wire logic                                         push,
    input  wire cefp_pkg::out_t                               push_data,
    input  wire logic                                         pop,
    output cefp_pkg::out_t                                    head,
    output logic                                              not_empty,
    output logic [$clog2(cefp_pkg::OUT_DEPTH + 1)-1:0]        count
);

    localparam int PW = $clog2(cefp_pkg::OUT_DEPTH);
    localparam int NW = $clog2(cefp_pkg::OUT_DEPTH + 1);

    cefp_pkg::out_t mem [cefp_pkg::OUT_DEPTH];
    logic [PW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [NW-1:0]  count_reg;

    assign head      = mem[rd_ptr_reg];
    assign not_empty = count_reg != '0;
    assign count     = count_reg;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            end
            count_reg <= count_reg + NW'(push) - NW'(pop);
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push && !pop |-> count_reg != NW'(cefp_pkg::OUT_DEPTH))
        else $error("result queue overflow");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> count_reg != '0)
        else $error("result queue underflow");

endmodule

`default_nettype wire

>>> src/canny_edge_front_pipeline_core.sv
// ============================================================================
// canny_edge_front_pipeline_core - Canny edge front end
// Gray, Gaussian blur, Sobel, non-maximum suppression and double threshold.
// ============================================================================
// One request is taken per clock for as long as results are drained: each
// stage reads its three rows from four row-slot line stores per quantity,
// each with one write and one read port, so one column per stage per clock.
// Step control rides the step registers to the result queue; the first
// result of a frame needs the producer stages to run a row plus two pixels
// ahead, flush requests drain the tail. Line stores aren't cleared on reset.
`default_nettype none

module canny_edge_front_pipeline_core #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4095
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire cefp_pkg::in_t                        s_data,
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output cefp_pkg::out_t                            m_data,
    input  wire logic                                 cfg_we,
    input  wire logic [1:0]                           cfg_index,
    input  wire logic [cefp_pkg::CFG_DATA_BITS-1:0]   cfg_wdata
);

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int PD = cefp_pkg::PIPE_DEPTH;
    localparam int NW = $clog2(cefp_pkg::OUT_DEPTH + 1);

    logic [10:0] frame_width_reg;
    logic [11:0] frame_height_reg;
    logic [7:0]  weak_level_reg, strong_level_reg;
    logic [WW-1:0] w_use;
    logic [HW-1:0] h_use;

    logic in_accept;
    cefp_pkg::step_t step;
    cefp_pkg::step_t pipe_reg [PD];

    logic [14:0] x_reg;
    logic [27:0] gray_prod;
    logic [7:0]  gray_val;

    logic [7:0] gray_rd [4];
    logic [7:0] blur_rd [4];
    logic [7:0] mag_rd  [4];
    logic [1:0] sec_rd  [4];

    logic [7:0] bnew [3];
    logic [7:0] bw_reg [3][2];
    logic [7:0] blur_val;

    logic [7:0] snew [3];
    logic [7:0] sw_reg [3][2];
    logic signed [11:0] gx_full, gy_full;
    logic signed [10:0] gx_reg, gy_reg;
    logic [7:0] mag_val;
    logic [1:0] sec_val;

    logic [7:0] mnew [3];
    logic [7:0] mw_reg [3][2];
    logic [1:0] sc_new;
    cefp_pkg::sector_t sc_reg;
    cefp_pkg::out_t res;

    logic [NW-1:0] fifo_count;
    logic out_pop;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= 11'd640;
            frame_height_reg <= 12'd480;
            weak_level_reg   <= 8'd25;
            strong_level_reg <= 8'd180;
        end else if (cfg_we) begin
            unique case (cefp_pkg::cfg_reg_t'(cfg_index))
                cefp_pkg::REG_FRAME_WIDTH:  frame_width_reg  <= cfg_wdata[10:0];
                cefp_pkg::REG_FRAME_HEIGHT: frame_height_reg <= cfg_wdata[11:0];
                cefp_pkg::REG_WEAK_LEVEL:   weak_level_reg   <= cfg_wdata[7:0];
                cefp_pkg::REG_STRONG_LEVEL: strong_level_reg <= cfg_wdata[7:0];
            endcase
        end
    end

    assign w_use = (frame_width_reg < 11'd3) ? WW'(3) :
                   (32'(frame_width_reg) > MAX_WIDTH) ? WW'(MAX_WIDTH) :
                   WW'(frame_width_reg);
    assign h_use = (frame_height_reg < 12'd3) ? HW'(3) :
                   (32'(frame_height_reg) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) :
                   HW'(frame_height_reg);

    // request side
    assign s_ready   = fifo_count < NW'(cefp_pkg::OUT_DEPTH - PD);
    assign in_accept = s_valid && s_ready;

    cefp_ctrl #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT)
    ) u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .step_en(in_accept),
        .pixel  (s_data.command == cefp_pkg::CMD_PIXEL),
        .w_use  (w_use),
        .h_use  (h_use),
        .step   (step)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < PD; k++) begin
                pipe_reg[k] <= '0;
            end
        end else begin
            pipe_reg[0] <= in_accept ? step : '0;
            for (int k = 1; k < PD; k++) begin
                pipe_reg[k] <= pipe_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            x_reg <= 15'(30 * 32'(s_data.red) + 59 * 32'(s_data.green) +
                         11 * 32'(s_data.blue) + 50);
        end
    end

    assign gray_prod = 28'(x_reg) * 28'(cefp_pkg::GRAY_RECIP);
    assign gray_val  = gray_prod[cefp_pkg::GRAY_SHIFT +: 8];

    // line stores, one per row slot and quantity
    for (genvar g = 0; g < 4; g++) begin : g_slot
        cefp_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_gray (
            .aclk (aclk),
            .we   (pipe_reg[0].stg[cefp_pkg::STG_GRAY].go &&
                   pipe_reg[0].stg[cefp_pkg::STG_GRAY].cur_slot == 2'(g)),
            .waddr(pipe_reg[0].stg[cefp_pkg::STG_GRAY].cur_col[CW-1:0]),
            .wdata(gray_val),
            .raddr(pipe_reg[1].stg[cefp_pkg::STG_BLUR].nxt_col[CW-1:0]),
            .rdata(gray_rd[g])
        );
        cefp_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_blur (
            .aclk (aclk),
            .we   (pipe_reg[2].stg[cefp_pkg::STG_BLUR].go &&
                   pipe_reg[2].stg[cefp_pkg::STG_BLUR].cur_slot == 2'(g)),
            .waddr(pipe_reg[2].stg[cefp_pkg::STG_BLUR].cur_col[CW-1:0]),
            .wdata(blur_val),
            .raddr(pipe_reg[3].stg[cefp_pkg::STG_SOBEL].nxt_col[CW-1:0]),
            .rdata(blur_rd[g])
        );
        cefp_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_mag (
            .aclk (aclk),
            .we   (pipe_reg[5].stg[cefp_pkg::STG_SOBEL].go &&
                   pipe_reg[5].stg[cefp_pkg::STG_SOBEL].cur_slot == 2'(g)),
            .waddr(pipe_reg[5].stg[cefp_pkg::STG_SOBEL].cur_col[CW-1:0]),
            .wdata(mag_val),
            .raddr(pipe_reg[6].stg[cefp_pkg::STG_SUPP].nxt_col[CW-1:0]),
            .rdata(mag_rd[g])
        );
        cefp_ram #(.WIDTH(2), .DEPTH(MAX_WIDTH)) u_sec (
            .aclk (aclk),
            .we   (pipe_reg[5].stg[cefp_pkg::STG_SOBEL].go &&
                   pipe_reg[5].stg[cefp_pkg::STG_SOBEL].cur_slot == 2'(g)),
            .waddr(pipe_reg[5].stg[cefp_pkg::STG_SOBEL].cur_col[CW-1:0]),
            .wdata(sec_val),
            .raddr(pipe_reg[6].stg[cefp_pkg::STG_SUPP].nxt_col[CW-1:0]),
            .rdata(sec_rd[g])
        );
    end

    // blur
    always_comb begin
        logic [9:0]  rsum [3];
        logic [11:0] sum;
        for (int d = 0; d < 3; d++) begin
            bnew[d] = gray_rd[2'(pipe_reg[2].stg[cefp_pkg::STG_BLUR].nxt_slot +
                                2'(d) + 2'd3)];
            rsum[d] = 10'(bw_reg[d][0]) + {1'b0, bw_reg[d][1], 1'b0} +
                      10'(bnew[d]);
        end
        sum = 12'(rsum[0]) + {1'b0, rsum[1], 1'b0} + 12'(rsum[2]);
        blur_val = pipe_reg[2].stg[cefp_pkg::STG_BLUR].border ? 8'd0 : sum[11:4];
    end

    always_ff @(posedge aclk) begin
        if (pipe_reg[2].stg[cefp_pkg::STG_BLUR].go) begin
            for (int d = 0; d < 3; d++) begin
                bw_reg[d][0] <= bw_reg[d][1];
                bw_reg[d][1] <= bnew[d];
            end
        end
    end

    // sobel
    function automatic logic signed [11:0] sx(input logic [7:0] v);
        return $signed({4'b0000, v});
    endfunction

    always_comb begin
        for (int d = 0; d < 3; d++) begin
            snew[d] = blur_rd[2'(pipe_reg[4].stg[cefp_pkg::STG_SOBEL].nxt_slot +
                                2'(d) + 2'd3)];
        end
        gx_full = (sx(snew[0]) - sx(sw_reg[0][0])) +
                  ((sx(snew[1]) - sx(sw_reg[1][0])) <<< 1) +
                  (sx(snew[2]) - sx(sw_reg[2][0]));
        gy_full = (sx(sw_reg[2][0]) - sx(sw_reg[0][0])) +
                  ((sx(sw_reg[2][1]) - sx(sw_reg[0][1])) <<< 1) +
                  (sx(snew[2]) - sx(snew[0]));
    end

    always_ff @(posedge aclk) begin
        gx_reg <= gx_full[10:0];
        gy_reg <= gy_full[10:0];
        if (pipe_reg[4].stg[cefp_pkg::STG_SOBEL].go) begin
            for (int d = 0; d < 3; d++) begin
                sw_reg[d][0] <= sw_reg[d][1];
                sw_reg[d][1] <= snew[d];
            end
        end
    end

    always_comb begin
        logic [10:0] ax_full, ay_full, ssum;
        logic [9:0]  ax, ay;
        logic [19:0] ay_sc, ax_lo, ax_hi;
        logic        same_sign;
        ax_full = gx_reg[10] ? 11'(-gx_reg) : gx_reg;
        ay_full = gy_reg[10] ? 11'(-gy_reg) : gy_reg;
        ax = ax_full[9:0];
        ay = ay_full[9:0];
        ssum = 11'(ax) + 11'(ay);
        ay_sc = {2'b00, ay, 8'h00};
        ax_lo = 20'(ax) * 20'(cefp_pkg::TAN_LOW);
        ax_hi = 20'(ax) * 20'(cefp_pkg::TAN_HIGH);
        same_sign = (!gx_reg[10] && gx_reg != '0) == (!gy_reg[10] && gy_reg != '0);
        if (pipe_reg[5].stg[cefp_pkg::STG_SOBEL].border) begin
            mag_val = 8'd0;
            sec_val = cefp_pkg::SEC_HORZ;
        end else begin
            mag_val = (ssum > 11'd255) ? 8'd255 : ssum[7:0];
            if (ay_sc <= ax_lo) begin
                sec_val = cefp_pkg::SEC_HORZ;
            end else if (ay_sc <= ax_hi) begin
                sec_val = same_sign ? cefp_pkg::SEC_DIAG_UP : cefp_pkg::SEC_DIAG_DOWN;
            end else begin
                sec_val = cefp_pkg::SEC_VERT;
            end
        end
    end

    // suppression and threshold
    always_comb begin
        logic [7:0] m, a, b;
        for (int d = 0; d < 3; d++) begin
            mnew[d] = mag_rd[2'(pipe_reg[7].stg[cefp_pkg::STG_SUPP].nxt_slot +
                               2'(d) + 2'd3)];
        end
        sc_new = sec_rd[pipe_reg[7].stg[cefp_pkg::STG_SUPP].nxt_slot];
        m = mw_reg[1][1];
        case (sc_reg)
            cefp_pkg::SEC_HORZ: begin
                a = mw_reg[1][0];
                b = mnew[1];
            end
            cefp_pkg::SEC_DIAG_UP: begin
                a = mnew[0];
                b = mw_reg[2][0];
            end
            cefp_pkg::SEC_VERT: begin
                a = mw_reg[0][1];
                b = mw_reg[2][1];
            end
            default: begin
                a = mw_reg[0][0];
                b = mnew[2];
            end
        endcase
        if (m < a || m < b) begin
            m = 8'd0;
        end
        res.last_pixel = pipe_reg[7].stg[cefp_pkg::STG_SUPP].last;
        if (pipe_reg[7].stg[cefp_pkg::STG_SUPP].border) begin
            res.magnitude  = 8'd0;
            res.edge_class = cefp_pkg::CLASS_NONE;
        end else begin
            res.magnitude = m;
            if (m >= strong_level_reg) begin
                res.edge_class = cefp_pkg::CLASS_STRONG;
            end else if (m >= weak_level_reg) begin
                res.edge_class = cefp_pkg::CLASS_WEAK;
            end else begin
                res.edge_class = cefp_pkg::CLASS_NONE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_reg[7].stg[cefp_pkg::STG_SUPP].go) begin
            for (int d = 0; d < 3; d++) begin
                mw_reg[d][0] <= mw_reg[d][1];
                mw_reg[d][1] <= mnew[d];
            end
            sc_reg <= cefp_pkg::sector_t'(sc_new);
        end
    end

    // result queue
    assign out_pop = m_valid && m_ready;

    cefp_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (pipe_reg[7].stg[cefp_pkg::STG_SUPP].go),
        .push_data(res),
        .pop      (out_pop),
        .head     (m_data),
        .not_empty(m_valid),
        .count    (fifo_count)
    );

    a_result_queued: assert property (@(posedge aclk) disable iff (!aresetn)
        pipe_reg[7].stg[cefp_pkg::STG_SUPP].go |=> m_valid)
        else $error("result lost on its way to the queue");

    a_credit: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept |-> fifo_count + NW'(PD) < NW'(cefp_pkg::OUT_DEPTH))
        else $error("request taken without queue room");

endmodule

`default_nettype wire

>>> tb/tb_canny_edge_front_pipeline_core.sv
// ============================================================================
// tb_canny_edge_front_pipeline_core - self-checking bench for the edge core
// Streams RGB frames and flush ticks through the core under random gaps and
// stalls. A behavioural model of the gray/blur/Sobel/suppression pipeline
// predicts every edge result, which the monitor checks field by field.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module tb_canny_edge_front_pipeline_core;
    import cefp_pkg::*;

    localparam int    MAX_W      = 1024;
    localparam int    MAX_H      = 4095;
    localparam logic  CMD_FLUSH  = ~CMD_PIXEL;
    localparam int    STALL_MAX  = 5000;

    logic                     aclk      = 1'b0;
    logic                     aresetn   = 1'b0;
    logic                     s_valid   = 1'b0;
    logic                     s_ready;
    in_t                      s_data    = '0;
    logic                     m_valid;
    logic                     m_ready   = 1'b0;
    out_t                     m_data;
    logic                     cfg_we    = 1'b0;
    logic [1:0]               cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;

    canny_edge_front_pipeline_core #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    in_t  request_queue[$];
    out_t edge_queue[$];
    int   mismatches   = 0;
    bit   calm_mode    = 1'b0;
    bit   hold_sink    = 1'b0;

    // ------------------------------------------------------------------
    // edge model
    // ------------------------------------------------------------------
    logic [7:0] gray_mem [4*MAX_W];
    logic [7:0] blur_mem [4*MAX_W];
    logic [7:0] grad_mem [4*MAX_W];
    sector_t    dir_mem  [4*MAX_W];
    int frame_w_reg = 640, frame_h_reg = 480, weak_reg = 25, strong_reg = 180;
    int g_row = 0, g_col = 0, g_slot = 0;
    int b_row = 0, b_col = 0, b_slot = 0;
    int d_row = 0, d_col = 0, d_slot = 0;
    int o_row = 0, o_col = 0, o_slot = 0;
    int ahead_gray = 0, ahead_blur = 0, ahead_grad = 0;

    function automatic int width_now();
        return (frame_w_reg < 3) ? 3 : (frame_w_reg > MAX_W) ? MAX_W : frame_w_reg;
    endfunction

    function automatic int height_now();
        return (frame_h_reg < 3) ? 3 : (frame_h_reg > MAX_H) ? MAX_H : frame_h_reg;
    endfunction

    function automatic int addr(int slot, int rel, int col);
        int c;
        c = (col >= MAX_W) ? MAX_W - 1 : col;
        return ((slot + rel + 3) & 3) * MAX_W + c;
    endfunction

    function automatic bit is_border(int row, int col);
        return row == 0 || row + 1 >= height_now() || col == 0 || col + 1 >= width_now();
    endfunction

    function automatic bit stage_go(int lead, int row, int col);
        longint rem, need;
        rem  = longint'(height_now() - row) * width_now() - col;
        need = width_now() + 2;
        if (rem < 1) rem = 1;
        if (rem < need) need = rem;
        return lead >= need;
    endfunction

    task automatic step_pos(inout int row, inout int col, inout int slot);
        if (col + 1 >= width_now()) begin
            col  = 0;
            slot = (slot + 1) & 3;
            row  = (row + 1 >= height_now()) ? 0 : row + 1;
        end else begin
            col++;
        end
    endtask

    task automatic predict_edges(in_t req);
        int   sum, gx, gy, ax, ay, m, na, nb;
        int   p[3][3];
        out_t res;
        if (req.command == CMD_PIXEL) begin
            gray_mem[addr(g_slot, 1, g_col)] =
                (30 * req.red + 59 * req.green + 11 * req.blue + 50) / 100;
            step_pos(g_row, g_col, g_slot);
            ahead_gray++;
        end
        if (stage_go(ahead_gray, b_row, b_col)) begin
            sum = 0;
            if (!is_border(b_row, b_col)) begin
                for (int r = 0; r < 3; r++)
                    for (int c = 0; c < 3; c++)
                        sum += ((r == 1 ? 2 : 1) * (c == 1 ? 2 : 1)) *
                               gray_mem[addr(b_slot, r, b_col - 1 + c)];
            end
            blur_mem[addr(b_slot, 1, b_col)] = sum >> 4;
            step_pos(b_row, b_col, b_slot);
            ahead_gray--;
            ahead_blur++;
        end
        if (stage_go(ahead_blur, d_row, d_col)) begin
            m = 0;
            dir_mem[addr(d_slot, 1, d_col)] = SEC_HORZ;
            if (!is_border(d_row, d_col)) begin
                for (int r = 0; r < 3; r++)
                    for (int c = 0; c < 3; c++)
                        p[r][c] = blur_mem[addr(d_slot, r, d_col - 1 + c)];
                gx = (p[0][2] - p[0][0]) + 2 * (p[1][2] - p[1][0]) + (p[2][2] - p[2][0]);
                gy = (p[2][0] - p[0][0]) + 2 * (p[2][1] - p[0][1]) + (p[2][2] - p[0][2]);
                ax = gx < 0 ? -gx : gx;
                ay = gy < 0 ? -gy : gy;
                m  = (ax + ay > 255) ? 255 : ax + ay;
                if (256 * ay <= TAN_LOW * ax)
                    dir_mem[addr(d_slot, 1, d_col)] = SEC_HORZ;
                else if (256 * ay <= TAN_HIGH * ax)
                    dir_mem[addr(d_slot, 1, d_col)] =
                        ((gx > 0) == (gy > 0)) ? SEC_DIAG_UP : SEC_DIAG_DOWN;
                else
                    dir_mem[addr(d_slot, 1, d_col)] = SEC_VERT;
            end
            grad_mem[addr(d_slot, 1, d_col)] = m;
            step_pos(d_row, d_col, d_slot);
            ahead_blur--;
            ahead_grad++;
        end
        if (stage_go(ahead_grad, o_row, o_col)) begin
            res = '0;
            if (!is_border(o_row, o_col)) begin
                m = grad_mem[addr(o_slot, 1, o_col)];
                case (dir_mem[addr(o_slot, 1, o_col)])
                    SEC_HORZ: begin
                        na = grad_mem[addr(o_slot, 1, o_col - 1)];
                        nb = grad_mem[addr(o_slot, 1, o_col + 1)];
                    end
                    SEC_DIAG_UP: begin
                        na = grad_mem[addr(o_slot, 0, o_col + 1)];
                        nb = grad_mem[addr(o_slot, 2, o_col - 1)];
                    end
                    SEC_VERT: begin
                        na = grad_mem[addr(o_slot, 0, o_col)];
                        nb = grad_mem[addr(o_slot, 2, o_col)];
                    end
                    default: begin
                        na = grad_mem[addr(o_slot, 0, o_col - 1)];
                        nb = grad_mem[addr(o_slot, 2, o_col + 1)];
                    end
                endcase
                if (m < na || m < nb) m = 0;
                res.magnitude  = m;
                res.edge_class = (m >= strong_reg) ? CLASS_STRONG :
                                 (m >= weak_reg)   ? CLASS_WEAK : CLASS_NONE;
            end
            res.last_pixel = (o_col + 1 >= width_now() && o_row + 1 >= height_now());
            edge_queue.push_back(res);
            step_pos(o_row, o_col, o_slot);
            ahead_grad--;
        end
    endtask

    function automatic bit model_drained();
        return ahead_gray == 0 && ahead_blur == 0 && ahead_grad == 0 &&
               o_row == 0 && o_col == 0 && g_row == 0 && g_col == 0;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_request(logic cmd, int r, int g, int b);
        in_t req;
        req.command = cmd;
        req.red     = r;
        req.green   = g;
        req.blue    = b;
        predict_edges(req);
        request_queue.push_back(req);
    endtask

    task automatic queue_pixel_rand();
        queue_request(CMD_PIXEL, $urandom_range(0, 255), $urandom_range(0, 255),
                      $urandom_range(0, 255));
    endtask

    task automatic queue_frame(int flush_pct);
        for (int i = 0; i < width_now() * height_now(); i++) begin
            if ($urandom_range(0, 99) < flush_pct)
                queue_request(CMD_FLUSH, $urandom_range(0, 255), 0, 0);
            queue_pixel_rand();
        end
    endtask

    task automatic queue_drain();
        while (!model_drained())
            queue_request(CMD_FLUSH, 0, $urandom_range(0, 255), $urandom_range(0, 255));
    endtask

    task automatic wait_idle();
        while (request_queue.size() != 0 || s_valid || edge_queue.size() != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_reg_t idx, int value);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        case (idx)
            REG_FRAME_WIDTH:  frame_w_reg = value & 'h7FF;
            REG_FRAME_HEIGHT: frame_h_reg = value & 'hFFF;
            REG_WEAK_LEVEL:   weak_reg    = value & 'hFF;
            default:          strong_reg  = value & 'hFF;
        endcase
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (calm_mode || roll < 65) return 0;
        if (roll < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // ------------------------------------------------------------------
    // driver
    // ------------------------------------------------------------------
    int send_gap = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (send_gap > 0) begin
                s_valid <= 1'b0;
                send_gap--;
            end else if (request_queue.size() != 0) begin
                s_valid  <= 1'b1;
                s_data   <= request_queue.pop_front();
                send_gap = pick_gap();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor
    // ------------------------------------------------------------------
    int sink_gap = 0;
    always @(posedge aclk) begin
        out_t exp_res;
        if (aresetn && m_valid && m_ready) begin
            if (edge_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %p", m_data);
            end else begin
                exp_res = edge_queue.pop_front();
                if (m_data.edge_class !== exp_res.edge_class ||
                    m_data.magnitude  !== exp_res.magnitude ||
                    m_data.last_pixel !== exp_res.last_pixel) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: expected %p, got %p", exp_res, m_data);
                end
            end
        end
        if (hold_sink) begin
            hold_sink = 1'b0;
            sink_gap  = 400;
            m_ready  <= 1'b0;
        end else if (sink_gap > 0) begin
            sink_gap--;
            m_ready <= 1'b0;
        end else begin
            m_ready  <= aresetn;
            sink_gap = pick_gap();
        end
    end

    // ------------------------------------------------------------------
    // watchdog
    // ------------------------------------------------------------------
    int quiet_cycles = 0;
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) ||
            (request_queue.size() == 0 && !s_valid && edge_queue.size() == 0))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_MAX) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial begin
        int pixels_sent;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // small frame with saturated channels and a sharp step
        write_reg(REG_FRAME_WIDTH, 5);
        write_reg(REG_FRAME_HEIGHT, 4);
        write_reg(REG_WEAK_LEVEL, 0);
        write_reg(REG_STRONG_LEVEL, 255);
        queue_request(CMD_FLUSH, 255, 255, 255);
        for (int i = 0; i < 20; i++) begin
            if (i % 5 >= 2) queue_request(CMD_PIXEL, 255, 255, 255);
            else if (i % 5 == 1) queue_request(CMD_PIXEL, 255, 0, 0);
            else queue_request(CMD_PIXEL, 0, (i & 4) ? 255 : 0, 0);
        end
        queue_drain();
        wait_idle();

        // random frames, several settings
        pixels_sent = 0;
        for (int ph = 0; pixels_sent < 600; ph++) begin
            write_reg(REG_FRAME_WIDTH, $urandom_range(3, 10));
            write_reg(REG_FRAME_HEIGHT, $urandom_range(3, 7));
            write_reg(REG_WEAK_LEVEL, (ph == 1) ? 255 : $urandom_range(0, 60));
            write_reg(REG_STRONG_LEVEL, (ph == 2) ? 0 : $urandom_range(40, 255));
            calm_mode = (ph % 3 == 2);
            for (int f = $urandom_range(1, 3); f > 0; f--) begin
                queue_frame((ph % 2) ? 10 : 0);
                pixels_sent += width_now() * height_now();
            end
            queue_drain();
            if (ph == 1) begin
                repeat (5) @(posedge aclk);
                hold_sink = 1'b1;
            end
            wait_idle();
        end

        // size extremes, out-of-range values clamp
        calm_mode = 1'b1;
        write_reg(REG_FRAME_WIDTH, 2047);
        write_reg(REG_FRAME_HEIGHT, 2);
        queue_frame(0);
        queue_drain();
        wait_idle();
        write_reg(REG_FRAME_WIDTH, 0);
        write_reg(REG_FRAME_HEIGHT, 4095);
        queue_frame(0);
        queue_drain();
        wait_idle();

        if (edge_queue.size() != 0) mismatches++;
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire
